// ===== rtl/core/trivariate_polynomial_evaluator_macros.svh =====
// Assertion macros shared by the polynomial evaluator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TRIVARIATE_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define TRIVARIATE_POLYNOMIAL_EVALUATOR_MACROS_SVH

// same-cycle implication
`define TPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define TPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== rtl/core/tpe_pkg.sv =====
// Types and constants of the trivariate polynomial evaluator.
// No dependencies; used by the top level, tpe_csr and tpe_accum.
package tpe_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_POINT_X = 2'd0;
   localparam logic [1:0] REG_POINT_Y = 2'd1;
   localparam logic [1:0] REG_POINT_Z = 2'd2;

   localparam logic [63:0] TOP64   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TOO_BIG = 64'h8000_0000_0000_0001;
   localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;

   // finished term magnitude handed to the accumulator
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        zero;
      logic        neg;
      logic [63:0] mag;
   } acc_cmd_type;

endpackage

// ===== rtl/core/trivariate_polynomial_evaluator.sv =====
// Top level of the trivariate polynomial evaluator: term sequencer and
// magnitude datapath. Depends on tpe_pkg, tpe_csr, tpe_mult, tpe_accum.
//
// Usage: program point_x/y/z over the csr_ port (byte addresses 0, 4, 8)
// while idle, then stream terms on req_. Each transfer carries one term;
// req_tlast marks the final term of a polynomial. After the final term the
// saturated 64-bit sum appears on rsp_tdata with the sticky overflow flag on
// rsp_tuser, and the accumulator clears for the next polynomial.
// Sequencing: a term takes one sequencer step per variable visited, plus a
// closing step unless a zero coefficient or base ends the term; a term makes
// px + py + pz multiplications (exponents clamped to MAX_EXPONENT; none after
// a zero factor). Each multiplication is two 32-bit partial products on the
// single shared multiplier plus a recombine/saturate step. The sum passes the
// accumulator's term stage and result register after the last term leaves the
// sequencer. req_tready is high only between terms. While a
// result waits for rsp_tready further terms are still taken; only a following
// last term holds in the sequencer until the result register is free.
// Reset holds req_tready low and clears the point registers, the
// accumulator, the flag and any pending result.
`include "trivariate_polynomial_evaluator_macros.svh"

module trivariate_polynomial_evaluator #(
   parameter int MAX_EXPONENT = 15,
   parameter int VALUE_WIDTH  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: coefficient, power_x, power_y, power_z, zero fill
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((VALUE_WIDTH+12+7)/8)*8-1:0] req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: poly_value
   output logic [63:0]                        rsp_tdata,
   // tuser: overflowed
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tpe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tpe_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tpe_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int         CLAMP     = (MAX_EXPONENT < 15) ? MAX_EXPONENT : 15;
   localparam logic [3:0] CLAMP_EXP = 4'(CLAMP);
   localparam int         PW        = 32 + VALUE_WIDTH;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_BASE    = 3'd1;
   localparam logic [2:0] S_MUL_LO  = 3'd2;
   localparam logic [2:0] S_MUL_HI  = 3'd3;
   localparam logic [2:0] S_MUL_FIX = 3'd4;
   localparam logic [2:0] S_TERM    = 3'd5;

   localparam logic [1:0] VAR_X    = 2'd0;
   localparam logic [1:0] VAR_Y    = 2'd1;
   localparam logic [1:0] VAR_Z    = 2'd2;
   localparam logic [1:0] VAR_DONE = 2'd3;

   logic [VALUE_WIDTH-1:0] point_x, point_y, point_z;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             var_ff, var_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [63:0]            mag_ff, mag_in;
   logic                   neg_ff, neg_in, zero_ff, zero_in, last_ff, last_in;
   logic [3:0]             exp_x_ff, exp_y_ff, exp_z_ff;
   logic [VALUE_WIDTH-1:0] base_ff, base_in;
   logic [PW-1:0]          lo_ff;

   logic                   accept;
   logic [VALUE_WIDTH-1:0] coef, coef_mag;
   logic [3:0]             px, py, pz;
   logic [3:0]             cur_exp;
   logic [VALUE_WIDTH-1:0] cur_base, cur_base_mag;
   logic                   cur_base_neg;
   logic [31:0]            mul_a;
   logic                   mul_en;
   logic [PW-1:0]          product;
   logic [PW+31:0]         full;
   logic                   acc_ready;
   tpe_pkg::acc_cmd_type   acc_cmd;

   tpe_csr #(.VALUE_WIDTH(VALUE_WIDTH)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .point_x    (point_x),
      .point_y    (point_y),
      .point_z    (point_z)
   );

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid & req_tready;

   assign coef     = req_tdata[VALUE_WIDTH-1:0];
   assign coef_mag = coef[VALUE_WIDTH-1] ? (~coef + 1'b1) : coef;
   assign px = (req_tdata[VALUE_WIDTH+3:VALUE_WIDTH] > CLAMP_EXP) ? CLAMP_EXP
               : req_tdata[VALUE_WIDTH+3:VALUE_WIDTH];
   assign py = (req_tdata[VALUE_WIDTH+7:VALUE_WIDTH+4] > CLAMP_EXP) ? CLAMP_EXP
               : req_tdata[VALUE_WIDTH+7:VALUE_WIDTH+4];
   assign pz = (req_tdata[VALUE_WIDTH+11:VALUE_WIDTH+8] > CLAMP_EXP) ? CLAMP_EXP
               : req_tdata[VALUE_WIDTH+11:VALUE_WIDTH+8];

   always_comb begin
      unique case (var_ff)
         VAR_X:   begin cur_exp = exp_x_ff; cur_base = point_x; end
         VAR_Y:   begin cur_exp = exp_y_ff; cur_base = point_y; end
         VAR_Z:   begin cur_exp = exp_z_ff; cur_base = point_z; end
         default: begin cur_exp = '0;       cur_base = '0;      end
      endcase
   end

   assign cur_base_neg = cur_base[VALUE_WIDTH-1];
   assign cur_base_mag = cur_base_neg ? (~cur_base + 1'b1) : cur_base;

   // partial products: low half then high half of the running magnitude
   assign mul_en = (state_ff == S_MUL_LO) || (state_ff == S_MUL_HI);
   assign mul_a  = (state_ff == S_MUL_HI) ? mag_ff[63:32] : mag_ff[31:0];

   tpe_mult #(.VALUE_WIDTH(VALUE_WIDTH)) u_mult (
      .clock    (clock),
      .enable   (mul_en),
      .operand_a(mul_a),
      .operand_b(base_ff),
      .product  (product)
   );

   assign full = {product, 32'd0} + (PW + 32)'(lo_ff);

   always_comb begin
      state_in = state_ff;
      var_in   = var_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      last_in  = last_ff;
      base_in  = base_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mag_in   = 64'(coef_mag);
               neg_in   = coef[VALUE_WIDTH-1];
               zero_in  = (coef == '0);
               last_in  = req_tlast;
               var_in   = VAR_X;
               state_in = (coef == '0) ? S_TERM : S_BASE;
            end
         end
         S_BASE: begin
            if (var_ff == VAR_DONE) begin
               state_in = S_TERM;
            end else if (cur_exp == '0) begin
               var_in = var_ff + 2'd1;
            end else if (cur_base_mag == '0) begin
               zero_in  = 1'b1;
               state_in = S_TERM;
            end else begin
               neg_in   = neg_ff ^ (cur_base_neg & cur_exp[0]);
               cnt_in   = cur_exp;
               base_in  = cur_base_mag;
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO:  state_in = S_MUL_HI;
         S_MUL_HI:  state_in = S_MUL_FIX;
         S_MUL_FIX: begin
            mag_in = (full > (PW + 32)'(tpe_pkg::TOO_BIG)) ? tpe_pkg::TOO_BIG : full[63:0];
            if (cnt_ff == 4'd1) begin
               var_in   = var_ff + 2'd1;
               state_in = S_BASE;
            end else begin
               cnt_in   = cnt_ff - 4'd1;
               state_in = S_MUL_LO;
            end
         end
         S_TERM: begin
            if (acc_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         var_ff   <= VAR_X;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         var_ff   <= var_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      last_ff <= last_in;
      base_ff <= base_in;
      if (accept) begin
         exp_x_ff <= px;
         exp_y_ff <= py;
         exp_z_ff <= pz;
      end
      if (state_ff == S_MUL_HI) begin
         lo_ff <= product;
      end
   end

   assign acc_cmd.valid = (state_ff == S_TERM);
   assign acc_cmd.last  = last_ff;
   assign acc_cmd.zero  = zero_ff;
   assign acc_cmd.neg   = neg_ff;
   assign acc_cmd.mag   = mag_ff;

   tpe_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .cmd       (acc_cmd),
      .cmd_ready (acc_ready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   `TPE_ASSERT_IMPL(a_last_needs_free_rsp, clock, reset, acc_cmd.valid && acc_ready && acc_cmd.last, !rsp_tvalid)
   `TPE_ASSERT_NEXT(a_zero_coef_skips, clock, reset, accept && (coef == '0), state_ff == S_TERM)
   `TPE_ASSERT_IMPL(a_mag_bounded, clock, reset, state_ff != S_IDLE, mag_ff <= tpe_pkg::TOO_BIG)

endmodule

// ===== rtl/core/tpe_csr.sv =====
// APB-style register file holding the evaluation point.
// Depends on tpe_pkg.
module tpe_csr #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tpe_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [tpe_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [tpe_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output logic [VALUE_WIDTH-1:0]               point_x,
   output logic [VALUE_WIDTH-1:0]               point_y,
   output logic [VALUE_WIDTH-1:0]               point_z
);

   logic [VALUE_WIDTH-1:0] point_x_ff, point_y_ff, point_z_ff;
   logic [1:0]             reg_index;
   logic                   write_en;

   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff <= '0;
         point_y_ff <= '0;
         point_z_ff <= '0;
      end else if (write_en) begin
         unique case (reg_index)
            tpe_pkg::REG_POINT_X: point_x_ff <= csr_pwdata[VALUE_WIDTH-1:0];
            tpe_pkg::REG_POINT_Y: point_y_ff <= csr_pwdata[VALUE_WIDTH-1:0];
            tpe_pkg::REG_POINT_Z: point_z_ff <= csr_pwdata[VALUE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         tpe_pkg::REG_POINT_X: csr_prdata = tpe_pkg::CSR_DATA_WIDTH'(point_x_ff);
         tpe_pkg::REG_POINT_Y: csr_prdata = tpe_pkg::CSR_DATA_WIDTH'(point_y_ff);
         tpe_pkg::REG_POINT_Z: csr_prdata = tpe_pkg::CSR_DATA_WIDTH'(point_z_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign point_x = point_x_ff;
   assign point_y = point_y_ff;
   assign point_z = point_z_ff;

endmodule

// ===== rtl/core/tpe_mult.sv =====
// Shared 32 x VALUE_WIDTH unsigned multiplier with registered product.
// No package dependencies.
module tpe_mult #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [31:0]             operand_a,
   input  logic [VALUE_WIDTH-1:0]  operand_b,
   output logic [31+VALUE_WIDTH:0] product
);

   logic [31+VALUE_WIDTH:0] product_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= (32 + VALUE_WIDTH)'(operand_a) * (32 + VALUE_WIDTH)'(operand_b);
      end
   end

   assign product = product_ff;

endmodule

// ===== rtl/core/tpe_accum.sv =====
// Term saturation, saturating 64-bit accumulator and result register.
// Depends on tpe_pkg.
module tpe_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  tpe_pkg::acc_cmd_type cmd,
   output logic                 cmd_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,
   output logic                 rsp_tuser
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_last_ff, s1_flag_ff, s1_flag_in;
   logic [63:0] s1_term_ff, s1_term_in;
   logic [63:0] sum_ff, sum_in, raw_sum;
   logic        flag_ff, flag_in, add_ovf;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff;
   logic        rsp_user_ff;
   logic        take;

   assign cmd_ready   = !s1_valid_ff && (!cmd.last || !rsp_valid_ff);
   assign take        = cmd.valid && cmd_ready;
   assign s1_valid_in = take;

   always_comb begin
      s1_term_in = '0;
      s1_flag_in = 1'b0;
      if (!cmd.zero) begin
         if (cmd.neg) begin
            if (cmd.mag > tpe_pkg::TOP64) begin
               s1_term_in = tpe_pkg::TOP64;
               s1_flag_in = 1'b1;
            end else begin
               s1_term_in = 64'd0 - cmd.mag;
            end
         end else begin
            if (cmd.mag > tpe_pkg::POS_MAX) begin
               s1_term_in = tpe_pkg::POS_MAX;
               s1_flag_in = 1'b1;
            end else begin
               s1_term_in = cmd.mag;
            end
         end
      end
   end

   assign raw_sum = sum_ff + s1_term_ff;
   assign add_ovf = (sum_ff[63] == s1_term_ff[63]) && (raw_sum[63] != sum_ff[63]);

   always_comb begin
      sum_in       = sum_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (s1_valid_ff) begin
         sum_in  = add_ovf ? (sum_ff[63] ? tpe_pkg::TOP64 : tpe_pkg::POS_MAX) : raw_sum;
         flag_in = flag_ff | add_ovf | s1_flag_ff;
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && s1_last_ff) begin
            sum_ff  <= '0;
            flag_ff <= 1'b0;
         end else begin
            sum_ff  <= sum_in;
            flag_ff <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_term_ff <= s1_term_in;
         s1_flag_ff <= s1_flag_in;
         s1_last_ff <= cmd.last;
      end
      if (s1_valid_ff && s1_last_ff) begin
         rsp_data_ff <= sum_in;
         rsp_user_ff <= flag_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== dv/tpe_sum_checker.sv =====
// Checker for the trivariate polynomial evaluator: follows point writes and term
// transfers, predicts each saturated sum with its overflow flag and compares results.
// Depends on tpe_pkg for the CSR widths, register indexes and 64-bit bounds.
module tpe_sum_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // tdata: coefficient, power_x, power_y, power_z, zero fill
   input  logic [31:0]                        req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: poly_value
   input  logic [63:0]                        rsp_tdata,
   // tuser: overflowed
   input  logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tpe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tpe_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                               csr_pready,
   output int                                 fail_count,
   output int                                 pending_count
);
   import tpe_pkg::*;

   typedef struct packed {
      logic [63:0] value;
      logic        ovf;
   } poly_result_t;

   logic [15:0]  point_x;
   logic [15:0]  point_y;
   logic [15:0]  point_z;
   logic [63:0]  running_sum;
   logic         sum_ovf;
   poly_result_t expected_sums[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // magnitude times factor, clipped just above the 64-bit range
   function automatic logic [63:0] mul_clip(input logic [63:0] m, input logic [15:0] f);
      logic [79:0] p;
      p = m * f;
      return (p > {16'd0, TOO_BIG}) ? TOO_BIG : p[63:0];
   endfunction

   function automatic poly_result_t term_value(input logic [31:0] data);
      logic [15:0]  coef;
      logic [15:0]  base;
      logic [15:0]  base_mag;
      logic [3:0]   pw;
      logic [63:0]  m;
      logic         neg;
      logic         is_zero;
      poly_result_t r;
      coef    = data[15:0];
      neg     = coef[15];
      m       = {48'd0, coef[15] ? 16'(-coef) : coef};
      is_zero = (coef == 16'd0);
      for (int k = 0; k < 3; k++) begin
         base = (k == 0) ? point_x : (k == 1) ? point_y : point_z;
         pw   = data[16 + 4*k +: 4];
         if (pw != 4'd0) begin
            if (base == 16'd0) begin
               is_zero = 1'b1;
            end else begin
               base_mag = base[15] ? 16'(-base) : base;
               if (base[15] && pw[0]) neg = !neg;
               for (int i = 0; i < pw; i++) m = mul_clip(m, base_mag);
            end
         end
      end
      r.ovf = 1'b0;
      if (is_zero) begin
         r.value = 64'd0;
      end else if (neg) begin
         if (m > TOP64) begin
            r.value = TOP64;
            r.ovf   = 1'b1;
         end else begin
            r.value = -m;
         end
      end else if (m > POS_MAX) begin
         r.value = POS_MAX;
         r.ovf   = 1'b1;
      end else begin
         r.value = m;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      poly_result_t term;
      poly_result_t want;
      logic [64:0]  s;
      if (reset) begin
         point_x     = 16'd0;
         point_y     = 16'd0;
         point_z     = 16'd0;
         running_sum = 64'd0;
         sum_ovf     = 1'b0;
         expected_sums.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_POINT_X: point_x = csr_pwdata[15:0];
               REG_POINT_Y: point_y = csr_pwdata[15:0];
               REG_POINT_Z: point_z = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 64'd0);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("poly_value", rsp_tdata, want.value);
               if (rsp_tuser !== want.ovf)
                  report_mismatch("overflowed", 64'(rsp_tuser), 64'(want.ovf));
            end
         end
         if (req_tvalid && req_tready) begin
            term = term_value(req_tdata);
            if (term.ovf) sum_ovf = 1'b1;
            s = {running_sum[63], running_sum} + {term.value[63], term.value};
            if (s[64] != s[63]) begin
               running_sum = s[64] ? TOP64 : POS_MAX;
               sum_ovf     = 1'b1;
            end else begin
               running_sum = s[63:0];
            end
            if (req_tlast) begin
               expected_sums.push_back('{value: running_sum, ovf: sum_ovf});
               running_sum = 64'd0;
               sum_ovf     = 1'b0;
            end
         end
      end
      pending_count = expected_sums.size();
   end

endmodule

// ===== dv/trivariate_polynomial_evaluator_tb.sv =====
// Testbench top for the trivariate polynomial evaluator: drives point writes and
// term streams with random idling and one long result hold-off, then gives the verdict.
// Depends on tpe_pkg, the evaluator RTL and tpe_sum_checker.
module trivariate_polynomial_evaluator_tb;
   import tpe_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 100;
   localparam int RANDOM_PHASES = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_count;
   bit req_idle_on;
   bit rsp_idle_on;
   int hold_cycles;

   trivariate_polynomial_evaluator dut (.*);

   tpe_sum_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("trivariate_polynomial_evaluator_tb failed");
      $finish;
   end

   // result side: random stall bursts, plus a long hold-off on request
   initial begin : result_side
      int stall_left;
      stall_left  = 0;
      hold_cycles = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_term(input logic [15:0] coef, input logic [3:0] px,
                            input logic [3:0] py, input logic [3:0] pz, input logic last);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, pz, py, px, coef};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_point(input logic [1:0] index, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // drain all sums, then let any trailing term finish before touching registers
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_point(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
      write_point(REG_POINT_X, x);
      write_point(REG_POINT_Y, y);
      write_point(REG_POINT_Z, z);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'd0;
         3: return 16'($signed($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] pick_power();
      if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, 3));
   endfunction

   initial begin : stimulus
      int sent;
      int n;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // point at reset value: zero bases
      send_term(16'd5, 4'd0, 4'd0, 4'd0, 1'b1);
      send_term(16'd7, 4'd1, 4'd0, 4'd0, 1'b0);
      send_term(-16'sd3, 4'd0, 4'd0, 4'd0, 1'b1);
      send_term(16'h7fff, 4'd0, 4'd0, 4'd0, 1'b0);
      send_term(16'h8000, 4'd0, 4'd0, 4'd0, 1'b1);
      send_term(16'd0, 4'd15, 4'd15, 4'd15, 1'b1);
      settle();

      // extreme point; write to the spare index must be ignored
      set_point(16'h8000, 16'h7fff, 16'hffff);
      write_point(REG_UNUSED, 16'($urandom));
      send_term(16'h7fff, 4'd15, 4'd15, 4'd15, 1'b1);
      send_term(16'h8000, 4'd15, 4'd0, 4'd0, 1'b1);
      send_term(16'hffff, 4'd0, 4'd0, 4'd15, 1'b1);
      send_term(16'd7, 4'd4, 4'd0, 4'd0, 1'b0);
      send_term(16'd7, 4'd4, 4'd0, 4'd0, 1'b0);
      send_term(16'hffff, 4'd0, 4'd0, 4'd0, 1'b1);
      send_term(-16'sd8, 4'd4, 4'd0, 4'd0, 1'b1);
      send_term(16'd8, 4'd4, 4'd0, 4'd0, 1'b1);
      send_term(-16'sd8, 4'd4, 4'd0, 4'd0, 1'b0);
      send_term(16'hffff, 4'd0, 4'd0, 4'd0, 1'b1);
      send_term(16'd1, 4'd0, 4'd1, 4'd0, 1'b0);
      send_term(16'hffff, 4'd0, 4'd0, 4'd1, 1'b1);
      send_term(16'h8000, 4'd1, 4'd15, 4'd0, 1'b1);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_point(pick_value(), pick_value(), pick_value());
         if (p >= RANDOM_PHASES - 2) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         if (p == 2) hold_cycles = 2500;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            n = $urandom_range(1, 6);
            for (int t = 0; t < n; t++)
               send_term(pick_value(), pick_power(), pick_power(), pick_power(),
                         t == n - 1);
            sent += n;
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("trivariate_polynomial_evaluator_tb passed");
      end else begin
         $display("trivariate_polynomial_evaluator_tb failed");
      end
      $finish;
   end

endmodule
